// File: design/lpfs_pkg.sv
// ----------------------------------------------------------------------------
// lpfs_pkg: shared types and constants of the LED PWM frame serializer
// Holds the frame word constants, the word kind codes and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfs_pkg;

  localparam int unsigned ChanW  = 6;
  localparam int unsigned LevelW = 16;
  localparam int unsigned WordW  = 4;

  localparam logic [ChanW-1:0]  CH_PER_CHIP      = 6'd12;
  localparam logic [WordW-1:0]  FIRST_LEVEL_WORD = 4'd2;
  localparam logic [WordW-1:0]  LAST_WORD        = 4'd13;
  localparam logic [LevelW-1:0] CTRL_HI          = 16'h96DF;
  localparam logic [LevelW-1:0] CTRL_LO          = 16'hFFFF;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;

  typedef enum logic [1:0] {
    WORD_CTRL_HI = 2'd0,
    WORD_CTRL_LO = 2'd1,
    WORD_LEVEL   = 2'd2
  } word_kind_e;

  typedef struct packed {
    logic start;
    logic issue;
    logic write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic pipe_empty;
    logic stall;
  } ctrl_status_t;

endpackage

`default_nettype wire

// File: design/lpfs_in_if.sv
// ----------------------------------------------------------------------------
// lpfs_in_if: input item channel
// Valid/ready channel that carries one write or commit item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  channel;
  logic [15:0] level;

  modport source (output valid, output cmd, output channel, output level, input ready);
  modport sink   (input valid, input cmd, input channel, input level, output ready);
endinterface

`default_nettype wire

// File: design/lpfs_out_if.sv
// ----------------------------------------------------------------------------
// lpfs_out_if: result item channel
// Valid/ready channel that carries one frame word and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_word;
  logic        last_word;

  modport source (output valid, output frame_word, output last_word, input ready);
  modport sink   (input valid, input frame_word, input last_word, output ready);
endinterface

`default_nettype wire

// File: design/lpfs_ram.sv
// ----------------------------------------------------------------------------
// lpfs_ram: generic simple dual-port RAM
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/lpfs_datapath.sv
// ----------------------------------------------------------------------------
// lpfs_datapath: level store and frame word pipeline
// Holds the level RAM with its valid bits, the chip and word counters and a
// two-stage read pipeline that ends in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_datapath #(
  parameter int unsigned CHIPS = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lpfs_pkg::ctrl_cmd_t    cmd_i,
  output lpfs_pkg::ctrl_status_t      status_o,
  input  wire logic [5:0]             channel_i,
  input  wire logic [15:0]            level_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [15:0]                 frame_word_o,
  output logic                        last_word_o
);

  localparam int unsigned NumCh = CHIPS * 12;
  localparam int unsigned AddrW = $clog2(NumCh);
  localparam int unsigned ChipW = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam logic [5:0]       NUM_CH_W = 6'(NumCh);
  localparam logic [ChipW-1:0] TOP_CHIP = ChipW'(CHIPS - 1);

  logic [NumCh-1:0] valid_q;
  logic [ChipW-1:0] chip_q, chip_d;
  logic [lpfs_pkg::WordW-1:0] word_q, word_d;

  logic             s1_valid_q;
  logic             s1_last_q;
  logic             s1_ok_q;
  lpfs_pkg::word_kind_e s1_kind_q;

  logic        out_valid_q;
  logic [15:0] out_word_q;
  logic        out_last_q;

  logic             wr_en;
  logic             rd_en;
  logic             advance;
  logic             issue_last;
  logic [5:0]       rd_chan;
  logic [AddrW-1:0] raddr;
  logic [15:0]      ram_rdata;
  logic [15:0]      word_val;
  lpfs_pkg::word_kind_e issue_kind;

  assign wr_en      = cmd_i.write && (channel_i < NUM_CH_W);
  assign issue_last = (chip_q == '0) && (word_q == lpfs_pkg::LAST_WORD);
  assign advance    = !(out_valid_q && !out_ready_i);
  assign rd_en      = cmd_i.issue && (word_q >= lpfs_pkg::FIRST_LEVEL_WORD);

  // Channel order within a chip runs from 11 down to 0 as the word index grows.
  assign rd_chan = 6'(chip_q) * lpfs_pkg::CH_PER_CHIP
                 + {2'b00, lpfs_pkg::LAST_WORD - word_q};
  assign raddr   = rd_chan[AddrW-1:0];

  always_comb begin
    if (word_q == '0) begin
      issue_kind = lpfs_pkg::WORD_CTRL_HI;
    end else if (word_q == 4'd1) begin
      issue_kind = lpfs_pkg::WORD_CTRL_LO;
    end else begin
      issue_kind = lpfs_pkg::WORD_LEVEL;
    end
  end

  always_comb begin
    chip_d = chip_q;
    word_d = word_q;
    if (cmd_i.start) begin
      chip_d = TOP_CHIP;
      word_d = '0;
    end else if (cmd_i.issue) begin
      if (word_q == lpfs_pkg::LAST_WORD) begin
        word_d = '0;
        chip_d = chip_q - 1'b1;
      end else begin
        word_d = word_q + 1'b1;
      end
    end
  end

  always_comb begin
    unique case (s1_kind_q)
      lpfs_pkg::WORD_CTRL_HI: word_val = lpfs_pkg::CTRL_HI;
      lpfs_pkg::WORD_CTRL_LO: word_val = lpfs_pkg::CTRL_LO;
      lpfs_pkg::WORD_LEVEL:   word_val = s1_ok_q ? ram_rdata : '0;
      default:                word_val = '0;
    endcase
  end

  lpfs_ram #(
    .Width (16),
    .Depth (NumCh)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (channel_i[AddrW-1:0]),
    .wdata_i (level_i),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      chip_q      <= '0;
      word_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[channel_i[AddrW-1:0]] <= 1'b1;
      end
      chip_q <= chip_d;
      word_q <= word_d;
      if (advance) begin
        s1_valid_q  <= cmd_i.issue;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_kind_q <= issue_kind;
      s1_last_q <= issue_last;
      s1_ok_q   <= (issue_kind == lpfs_pkg::WORD_LEVEL) && valid_q[raddr];
    end
    if (advance) begin
      out_word_q <= word_val;
      out_last_q <= s1_last_q;
    end
  end

  assign status_o.issue_last = issue_last;
  assign status_o.pipe_empty = !s1_valid_q && !out_valid_q;
  assign status_o.stall      = !advance;

  assign out_valid_o  = out_valid_q;
  assign frame_word_o = out_word_q;
  assign last_word_o  = out_last_q;

endmodule

`default_nettype wire

// File: design/lpfs_controller.sv
// ----------------------------------------------------------------------------
// lpfs_controller: item sequencing state machine
// Accepts items while idle, runs the frame word issue and waits for the
// pipeline to drain before the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_controller (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_cmd_i,
  output logic                        in_ready_o,
  input  wire lpfs_pkg::ctrl_status_t status_i,
  output lpfs_pkg::ctrl_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == lpfs_pkg::CMD_COMMIT) begin
            cmd_o.start = 1'b1;
            state_d     = ST_RUN;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (!status_i.stall) begin
          cmd_o.issue = 1'b1;
          if (status_i.issue_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// File: design/led_pwm_frame_serializer_top.sv
// ----------------------------------------------------------------------------
// led_pwm_frame_serializer_top: LED PWM frame serializer
// Keeps grayscale levels for a chain of twelve-channel LED drivers and emits
// the chain frame as 16-bit words on a commit.
// ----------------------------------------------------------------------------
// A write item stores one 16-bit level; a write to a channel at or beyond
// CHIPS*12 is dropped. A commit item emits CHIPS*14 result items, chip by
// chip from the last chip down to the first: the control words 0x96DF and
// 0xFFFF, then channels 11 down to 0, with the last word flagged. The frame
// words come one per cycle while the sink takes them, so the frame length
// sets the pace. A commit occupies the block from its accepting cycle through
// the issue of each word, the final word's pass through the read stage and
// the output register, and the controller seeing the pipeline empty; a sink
// that holds off a waiting word stalls the issue and lengthens the commit.
// No new item is accepted until the frame has fully left the output
// register. The level store reads as zero after reset through per-channel
// valid flops, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pwm_frame_serializer_top #(
  parameter int unsigned CHIPS = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpfs_in_if.sink    in_i,
  lpfs_out_if.source out_o
);

  lpfs_pkg::ctrl_cmd_t    cmd;
  lpfs_pkg::ctrl_status_t status;

  // The controller owns the input handshake and decides what each cycle does.
  lpfs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath owns the level store and the output register.
  lpfs_datapath #(
    .CHIPS (CHIPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .channel_i    (in_i.channel),
    .level_i      (in_i.level),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .frame_word_o (out_o.frame_word),
    .last_word_o  (out_o.last_word)
  );

endmodule

`default_nettype wire
